>>> rtl/scirq_pkg.sv
package scirq_pkg;

    // Request kinds carried on the slave tuser field.
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_LATCH_WR  = 2'd1,
        CMD_CTRL_WR   = 2'd2,
        CMD_ACK       = 2'd3
    } cmd_t;

    // Bit positions inside the control word.
    localparam int unsigned CTL_ENABLE_AFTER_ACK = 0;
    localparam int unsigned CTL_ENABLE           = 1;
    localparam int unsigned CTL_CYCLE_MODE       = 2;

    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [6:0] PRESCALE_LONG  = 7'd114;
    localparam logic [6:0] PRESCALE_SHORT = 7'd113;
    localparam logic [1:0] PHASE_LAST     = 2'd2;

    // Scanline length for each prescaler phase; the unused fourth phase
    // behaves like the third.
    function automatic logic [6:0] prescale_divisor(input logic [1:0] phase);
        logic [6:0] div;
        div = (phase >= PHASE_LAST) ? PRESCALE_SHORT : PRESCALE_LONG;
        return div;
    endfunction

endpackage

>>> rtl/scanline_irq_counter_core.sv
// Scanline / cycle interrupt counter of a cartridge mapper.
//
// The slave stream carries one request per CPU cycle tick or register write.
// s_axis_tuser selects the request kind (tick, reload latch write, control
// write, acknowledge) and s_axis_tdata holds the written byte. For every
// accepted request the master stream returns exactly one result: the IRQ
// line level and the counter value after that request.
//
// A request accepted at one edge is presented on the master side from the
// next cycle on. One request per clock is taken while the receiver does not
// stall; the whole update (an 8-bit increment and compare plus the 7-bit
// prescaler compare) sits between the state registers and the result register.
//
// When the receiver stalls, the result stays in the output register and a
// new request is taken only in a cycle where that register is drained, so
// s_axis_tready follows m_axis_tready while a result is waiting.
//
// An asynchronous active-low reset clears the latch, the counter, the
// prescaler, the control word and the IRQ line, and empties the output.
module scanline_irq_counter_core
    import scirq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] wdata
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] irq_line, [8:1] count_value, [15:9] zero
);

    logic [7:0] reload_latch_reg, reload_latch_next;
    logic [7:0] up_counter_reg, up_counter_next;
    logic [6:0] prescale_count_reg, prescale_count_next;
    logic [1:0] prescale_phase_reg, prescale_phase_next;
    logic [2:0] control_reg, control_next;
    logic       irq_reg, irq_next;

    logic       out_valid_reg;
    logic [7:0] out_count_reg;
    logic       out_irq_reg;

    logic       req_accept;
    logic [6:0] prescale_inc;
    logic       scanline_done;
    logic       clock_counter;
    cmd_t       cmd;

    // The output register can take a new result when empty or being read.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign req_accept    = s_axis_tvalid && s_axis_tready;
    assign cmd           = cmd_t'(s_axis_tuser);

    assign prescale_inc  = prescale_count_reg + 7'd1;
    assign scanline_done = (prescale_inc >= prescale_divisor(prescale_phase_reg));

    always_comb
    begin
        reload_latch_next   = reload_latch_reg;
        up_counter_next     = up_counter_reg;
        prescale_count_next = prescale_count_reg;
        prescale_phase_next = prescale_phase_reg;
        control_next        = control_reg;
        irq_next            = irq_reg;
        clock_counter       = 1'b0;

        unique case (cmd)
            CMD_TICK:
            begin
                if (control_reg[CTL_ENABLE])
                begin
                    if (control_reg[CTL_CYCLE_MODE])
                    begin
                        clock_counter = 1'b1;
                    end
                    else if (scanline_done)
                    begin
                        prescale_count_next = 7'd0;
                        prescale_phase_next = (prescale_phase_reg >= PHASE_LAST) ?
                                              2'd0 : prescale_phase_reg + 2'd1;
                        clock_counter       = 1'b1;
                    end
                    else
                    begin
                        prescale_count_next = prescale_inc;
                    end
                end
            end
            CMD_LATCH_WR:
            begin
                reload_latch_next = s_axis_tdata;
            end
            CMD_CTRL_WR:
            begin
                // Upper bits of the control byte are dropped.
                control_next = s_axis_tdata[2:0];
                irq_next     = 1'b0;
                if (s_axis_tdata[CTL_ENABLE])
                begin
                    up_counter_next     = reload_latch_reg;
                    prescale_count_next = 7'd0;
                    prescale_phase_next = 2'd0;
                end
            end
            CMD_ACK:
            begin
                irq_next                 = 1'b0;
                control_next[CTL_ENABLE] = control_reg[CTL_ENABLE_AFTER_ACK];
            end
            default:
            begin
                irq_next = irq_reg;
            end
        endcase

        if (clock_counter)
        begin
            if (up_counter_reg == COUNT_MAX)
            begin
                up_counter_next = reload_latch_reg;
                irq_next        = 1'b1;
            end
            else
            begin
                up_counter_next = up_counter_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_latch_reg   <= 8'd0;
            up_counter_reg     <= 8'd0;
            prescale_count_reg <= 7'd0;
            prescale_phase_reg <= 2'd0;
            control_reg        <= 3'd0;
            irq_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                reload_latch_reg   <= reload_latch_next;
                up_counter_reg     <= up_counter_next;
                prescale_count_reg <= prescale_count_next;
                prescale_phase_reg <= prescale_phase_next;
                control_reg        <= control_next;
                irq_reg            <= irq_next;
                out_valid_reg      <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            out_count_reg <= up_counter_next;
            out_irq_reg   <= irq_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_count_reg, out_irq_reg};

`ifndef SYNTH
    // The IRQ line only rises on a counter wrap, which reloads the counter.
    a_irq_rise_reload: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_reg) |-> (up_counter_reg == reload_latch_reg))
        else $error("IRQ raised without a counter reload");

    // The prescaler never counts past the longest scanline.
    a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
        prescale_count_reg < PRESCALE_LONG)
        else $error("prescaler count out of range");

    // The unused prescaler phase is never entered.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        prescale_phase_reg != 2'd3)
        else $error("prescaler entered the unused phase");

    // A pending result always mirrors the current state.
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg == up_counter_reg) && (out_irq_reg == irq_reg))
        else $error("pending result disagrees with counter state");
`endif

endmodule

>>> tb/sv/scanline_irq_counter_core_test.sv
module scanline_irq_counter_core_test
    import scirq_pkg::*;
();

    // Control byte masks built from the bit positions of the control word.
    localparam logic [7:0] CTRL_AFTER_ACK = 8'(1 << CTL_ENABLE_AFTER_ACK);
    localparam logic [7:0] CTRL_EN        = 8'(1 << CTL_ENABLE);
    localparam logic [7:0] CTRL_CYCLE     = 8'(1 << CTL_CYCLE_MODE);

    // Once this many requests have gone out, neither side idles any more.
    localparam int TAIL_START   = 650;
    localparam int REQUEST_GOAL = 710;

    // The scoreboard keeps its own copy of the counter state. Every accepted
    // request is run through that copy, and the resulting IRQ level and
    // counter value are queued until the block presents its result.
    class irq_counter_scoreboard;
        localparam logic [6:0] LINE_LONG  = 7'd114;
        localparam logic [6:0] LINE_SHORT = 7'd113;

        logic [7:0] latch_q;
        logic [7:0] count_q;
        logic [6:0] line_ticks;
        logic [1:0] line_phase;
        logic [2:0] ctrl_q;
        logic       irq_q;
        logic [8:0] expected_results[$];
        int         errors;

        function new();
            latch_q    = '0;
            count_q    = '0;
            line_ticks = '0;
            line_phase = '0;
            ctrl_q     = '0;
            irq_q      = 1'b0;
            errors     = 0;
        endfunction

        // One clock of the 8-bit counter: wrap from the top reloads the
        // latch value and raises the IRQ line (a raised line stays high).
        function void clock_up_counter();
            if (count_q == 8'hFF)
            begin
                count_q = latch_q;
                irq_q   = 1'b1;
            end
            else
            begin
                count_q = count_q + 8'd1;
            end
        endfunction

        function void apply_tick();
            logic [6:0] line_len;
            if (!ctrl_q[CTL_ENABLE])
                return;
            if (ctrl_q[CTL_CYCLE_MODE])
            begin
                clock_up_counter();
                return;
            end
            // Scanline mode: the prescaler divides by 114, 114, 113 in turn.
            line_len   = (line_phase >= 2'd2) ? LINE_SHORT : LINE_LONG;
            line_ticks = line_ticks + 7'd1;
            if (line_ticks >= line_len)
            begin
                line_ticks = '0;
                line_phase = (line_phase >= 2'd2) ? 2'd0 : line_phase + 2'd1;
                clock_up_counter();
            end
        endfunction

        function void note_request(cmd_t cmd, logic [7:0] wdata);
            case (cmd)
                CMD_TICK:
                    apply_tick();
                CMD_LATCH_WR:
                    latch_q = wdata;
                CMD_CTRL_WR:
                begin
                    ctrl_q = wdata[2:0];
                    irq_q  = 1'b0;
                    if (ctrl_q[CTL_ENABLE])
                    begin
                        count_q    = latch_q;
                        line_ticks = '0;
                        line_phase = '0;
                    end
                end
                default:
                begin
                    irq_q              = 1'b0;
                    ctrl_q[CTL_ENABLE] = ctrl_q[CTL_ENABLE_AFTER_ACK];
                end
            endcase
            expected_results.push_back({count_q, irq_q});
        endfunction

        function void check_result(logic [15:0] got);
            logic [8:0] want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result %h with no request outstanding", $time, got);
                return;
            end
            want = expected_results.pop_front();
            if (got[0] !== want[0])
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: irq_line expected %b actual %b", $time, want[0], got[0]);
            end
            if (got[8:1] !== want[8:1])
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: count_value expected %h actual %h",
                             $time, want[8:1], got[8:1]);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;

    irq_counter_scoreboard sb = new();

    int   sent_count = 0;
    int   rx_hold = 0;
    logic quiet_tail = 1'b0;
    logic tx_gaps_on = 1'b1;
    logic rx_gaps_on = 1'b1;

    scanline_irq_counter_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] wdata
        .s_axis_tuser  (s_axis_tuser),   // [1:0] cmd
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [0] irq_line, [8:1] count_value, [15:9] zero
    );

    // 12 time unit clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Both handshakes are observed at the rising edge. The result is checked
    // before the request of the same edge is noted, because a result that
    // leaves at this edge always belongs to an older request.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (s_axis_tvalid && s_axis_tready)
            sb.note_request(cmd_t'(s_axis_tuser), s_axis_tdata);
    end

    // The receiver stalls in bursts of random length while stalls are
    // allowed, and stays ready during the tail of the run.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end
        else if (!quiet_tail && rx_gaps_on && $urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= $urandom_range(0, 16);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Drops tvalid for a pause whose length the argument gives.
    task automatic sender_pause(input int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Presents one request and holds it until the block takes it. Inputs
    // change only at the falling edge, so a request that follows directly
    // keeps tvalid high without a second assignment in the same step.
    task automatic send_request(input cmd_t cmd, input logic [7:0] wdata);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= wdata;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
        if (sent_count >= TAIL_START)
            quiet_tail = 1'b1;
        if (tx_gaps_on && !quiet_tail && $urandom_range(0, 7) == 0)
            sender_pause($urandom_range(1, 17));
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Control byte with the requested low bits and random upper bits, which
    // the block must drop.
    function automatic logic [7:0] ctrl_byte(input logic en, input logic cycle,
                                             input logic after_ack);
        logic [7:0] b;
        b = (8'($urandom) & 8'hF8)
            | (en ? CTRL_EN : 8'h00)
            | (cycle ? CTRL_CYCLE : 8'h00)
            | (after_ack ? CTRL_AFTER_ACK : 8'h00);
        return b;
    endfunction

    // A run of ticks with random ignored data; now and then an acknowledge
    // or a latch rewrite lands in the middle of the run.
    task automatic tick_run(input int count, input int ack_odds, input int latch_odds);
        repeat (count)
        begin
            if (ack_odds > 0 && $urandom_range(1, ack_odds) == 1)
                send_request(CMD_ACK, 8'($urandom));
            else if (latch_odds > 0 && $urandom_range(1, latch_odds) == 1)
                send_request(CMD_LATCH_WR, 8'($urandom));
            else
                send_request(CMD_TICK, 8'($urandom));
        end
    endtask

    initial
    begin
        int kind;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A tick right after reset must change nothing.
        send_request(CMD_TICK, 8'hFF);
        send_request(CMD_LATCH_WR, 8'hFF);
        // Only upper bits set: counting stays disabled.
        send_request(CMD_CTRL_WR, 8'hF8);
        send_request(CMD_TICK, 8'h00);
        // Upper bits are dropped; cycle mode enabled, counter loads 0xFF.
        send_request(CMD_CTRL_WR, 8'hFE);
        // Two overflows in a row: the second keeps the IRQ line high.
        send_request(CMD_TICK, 8'hFF);
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_LATCH_WR, 8'h00);
        send_request(CMD_TICK, 8'hAA);
        // Acknowledge with enable-after-ack clear disables counting.
        send_request(CMD_ACK, 8'hFF);
        send_request(CMD_TICK, 8'h55);
        send_request(CMD_CTRL_WR, 8'h07);
        send_request(CMD_TICK, 8'h00);
        // Acknowledge with enable-after-ack set keeps counting on.
        send_request(CMD_ACK, 8'h00);
        send_request(CMD_TICK, 8'hFF);
        // Scanline mode: the prescaler must not clock the counter yet.
        send_request(CMD_LATCH_WR, 8'hFE);
        send_request(CMD_CTRL_WR, 8'h03);
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_TICK, 8'hFF);
        send_request(CMD_ACK, 8'h5A);
        send_request(CMD_TICK, 8'h00);
        // Disabling write leaves the counter value as it is.
        send_request(CMD_CTRL_WR, 8'h00);
        send_request(CMD_ACK, 8'hA5);
        send_request(CMD_TICK, 8'hFF);

        // The sender waits here until the block has answered everything.
        drain_results();

        // A full prescaler cycle with wrap back to the first phase; the latch
        // at 0xFF makes every scanline overflow the counter.
        send_request(CMD_LATCH_WR, 8'hFF);
        send_request(CMD_CTRL_WR, ctrl_byte(1'b1, 1'b0, 1'b0));
        tick_run(345, 0, 0);

        while (sent_count < REQUEST_GOAL)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // Cycle mode run, latch mostly near the top so it overflows.
                if ($urandom_range(0, 1) == 0)
                    send_request(CMD_LATCH_WR, 8'($urandom_range(8'hF0, 8'hFF)));
                else
                    send_request(CMD_LATCH_WR, 8'($urandom));
                send_request(CMD_CTRL_WR, ctrl_byte(1'b1, 1'b1, 1'($urandom)));
                tick_run($urandom_range(1, 40), 12, 30);
            end
            else if (kind < 55)
            begin
                // Scanline mode run of random length.
                send_request(CMD_LATCH_WR, 8'($urandom_range(8'hFC, 8'hFF)));
                send_request(CMD_CTRL_WR, ctrl_byte(1'b1, 1'b0, 1'($urandom)));
                tick_run($urandom_range(1, 240), 100, 60);
            end
            else if (kind < 70)
            begin
                // Disabled counting, then acknowledges that may re-enable it.
                send_request(CMD_CTRL_WR, ctrl_byte(1'b0, 1'($urandom), 1'($urandom)));
                tick_run($urandom_range(1, 6), 0, 0);
                send_request(CMD_ACK, 8'($urandom));
                tick_run($urandom_range(1, 10), 5, 0);
            end
            else if (kind < 75)
            begin
                if (!quiet_tail)
                    drain_results();
            end
            else
            begin
                // Noise: any request with any data.
                repeat ($urandom_range(1, 12))
                    send_request(cmd_t'($urandom_range(0, 3)), 8'($urandom));
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("scanline_irq_counter_core: match");
        else
            $display("scanline_irq_counter_core: mismatch");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #4_800_000;
        $display("scanline_irq_counter_core: mismatch");
        $finish;
    end

endmodule
